### rtl/alpha_map_decoder_defines.svh
// Assertion macros used by the checker file.
`ifndef ALPHA_MAP_DECODER_DEFINES_SVH
`define ALPHA_MAP_DECODER_DEFINES_SVH

// Checked only while out of reset.
`define AMD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("alpha map decoder check failed");

// Checked at every edge, reset included.
`define AMD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("alpha map decoder reset check failed");

`endif

### rtl/amd_pkg.sv
package amd_pkg;

    typedef enum logic [1:0] {
        MODE_RLE  = 2'd0,
        MODE_RAW  = 2'd1,
        MODE_PACK = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_FILL,
        PH_LIT
    } t_phase;

    typedef enum logic {
        ES_IDLE,
        ES_RUN
    } t_emit_state;

    // One decoded byte: texels to write and whether the layer ends after it.
    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] count;
        logic       clear;
    } t_job;

    localparam logic [7:0] CMD_FILL_BIT = 8'h80;
    localparam logic [7:0] CMD_LEN_MASK = 8'h7F;

    // nibble * 17 == nibble replicated into both halves
    function automatic logic [7:0] scale17(input logic [3:0] nib);
        logic [7:0] res;
        res = {nib, 4'b0000} + {4'b0000, nib};
        return res;
    endfunction

endpackage

### rtl/alpha_map_decoder.sv
// Channel   Direction  Beat                               Handshake
// cfg       in         alpha_mode                         i_cfg_we
// in        in         in_byte, layer_end                 i_in_valid / o_in_stall
// out       out        texel pair, count, position, last  o_out_valid / i_out_stall
//
// A byte is taken while the emitter is idle; a byte giving results then holds o_in_stall
// while its texel pairs go out from the shared position step, and while a full map
// swallows it. Command bytes and no-alpha mode give no results and do not stall.
// Output stalls lengthen the input stall.
// Synchronous active-low reset; mode resets to no alpha.
module alpha_map_decoder #(
    parameter int MAP_TEXELS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_layer_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_texel_first,
    output logic [7:0]  o_texel_second,
    output logic [1:0]  o_pair_count,
    output logic [11:0] o_texel_position,
    output logic        o_run_last
);
    import amd_pkg::*;

    t_mode r_mode;
    t_job  job;
    logic  accept;
    logic  busy;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    amd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_in_byte),
        .i_end   (i_layer_end),
        .i_mode  (r_mode),
        .o_job   (job)
    );

    amd_emit #(
        .MAP_TEXELS(MAP_TEXELS)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_job           (job),
        .o_busy          (busy),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_texel_first   (o_texel_first),
        .o_texel_second  (o_texel_second),
        .o_pair_count    (o_pair_count),
        .o_texel_position(o_texel_position),
        .o_run_last      (o_run_last)
    );

endmodule

### rtl/amd_parse.sv
module amd_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_end,
    input  amd_pkg::t_mode i_mode,
    output amd_pkg::t_job  o_job
);
    import amd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_run, n_run;
    logic [7:0] run_dec;

    assign run_dec = (r_run != 8'd0) ? (r_run - 8'd1) : 8'd0;

    always_comb begin
        n_phase      = r_phase;
        n_run        = r_run;
        o_job.first  = i_byte;
        o_job.second = 8'd0;
        o_job.count  = 8'd0;
        o_job.clear  = i_end;
        case (i_mode)
            MODE_RLE: begin
                case (r_phase)
                    PH_CMD: begin
                        n_run   = (i_byte & CMD_LEN_MASK) + 8'd1;
                        n_phase = ((i_byte & CMD_FILL_BIT) != 8'd0) ? PH_FILL : PH_LIT;
                    end
                    PH_FILL: begin
                        o_job.second = i_byte;
                        o_job.count  = r_run;
                        n_run        = 8'd0;
                        n_phase      = PH_CMD;
                    end
                    PH_LIT: begin
                        o_job.count = 8'd1;
                        n_run       = run_dec;
                        if (run_dec == 8'd0) begin
                            n_phase = PH_CMD;
                        end
                    end
                    default: begin
                        n_phase = PH_CMD;
                    end
                endcase
            end
            MODE_RAW: begin
                o_job.count = 8'd1;
            end
            MODE_PACK: begin
                o_job.first  = scale17(i_byte[3:0]);
                o_job.second = scale17(i_byte[7:4]);
                o_job.count  = 8'd2;
            end
            default: begin
                o_job.count = 8'd0;
            end
        endcase
        if (i_end) begin
            n_phase = PH_CMD;
            n_run   = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_run   <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_run   <= n_run;
        end
    end

endmodule

### rtl/amd_emit.sv
module amd_emit #(
    parameter int MAP_TEXELS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  amd_pkg::t_job i_job,
    output logic          o_busy,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_texel_first,
    output logic [7:0]    o_texel_second,
    output logic [1:0]    o_pair_count,
    output logic [11:0]   o_texel_position,
    output logic          o_run_last
);
    import amd_pkg::*;

    localparam int PW = $clog2(MAP_TEXELS + 1);
    localparam logic [PW-1:0] MAP_W = PW'(MAP_TEXELS);

    t_emit_state r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_n, n_n;
    logic [7:0]    r_first, n_first;
    logic [7:0]    r_second, n_second;
    logic          r_clr, n_clr;
    logic          r_ov, n_ov;
    logic [7:0]    r_o_first, n_o_first;
    logic [7:0]    r_o_second, n_o_second;
    logic [1:0]    r_o_cnt, n_o_cnt;
    logic [11:0]   r_o_pos, n_o_pos;
    logic          r_o_last, n_o_last;

    logic [PW-1:0] pos_p1, pos_p2, step_pos;
    logic [7:0]    rem;
    logic          full, two, last, out_free;

    // shared position step and limit compare
    assign pos_p1   = r_pos + PW'(1);
    assign pos_p2   = r_pos + PW'(2);
    assign full     = (r_pos >= MAP_W);
    assign two      = (r_n >= 8'd2) && (pos_p1 < MAP_W);
    assign step_pos = two ? pos_p2 : pos_p1;
    assign rem      = r_n - (two ? 8'd2 : 8'd1);
    assign last     = (rem == 8'd0) || (step_pos >= MAP_W);
    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_n        = r_n;
        n_first    = r_first;
        n_second   = r_second;
        n_clr      = r_clr;
        n_ov       = out_free ? 1'b0 : r_ov;
        n_o_first  = r_o_first;
        n_o_second = r_o_second;
        n_o_cnt    = r_o_cnt;
        n_o_pos    = r_o_pos;
        n_o_last   = r_o_last;
        case (r_state)
            ES_IDLE: begin
                if (i_accept) begin
                    n_first  = i_job.first;
                    n_second = i_job.second;
                    n_n      = i_job.count;
                    n_clr    = i_job.clear;
                    if (i_job.count == 8'd0) begin
                        if (i_job.clear) begin
                            n_pos = '0;
                        end
                    end else begin
                        n_state = ES_RUN;
                    end
                end
            end
            ES_RUN: begin
                if (full) begin
                    // map already full: byte is swallowed
                    n_state = ES_IDLE;
                    if (r_clr) begin
                        n_pos = '0;
                    end
                end else if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_first  = r_first;
                    n_o_second = two ? r_second : 8'd0;
                    n_o_cnt    = two ? 2'd2 : 2'd1;
                    n_o_pos    = 12'(r_pos);
                    n_o_last   = last;
                    n_pos      = step_pos;
                    n_n        = rem;
                    if (last) begin
                        n_state = ES_IDLE;
                        if (r_clr) begin
                            n_pos = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = ES_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
            r_pos   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_first    <= n_first;
        r_second   <= n_second;
        r_clr      <= n_clr;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
        r_o_cnt    <= n_o_cnt;
        r_o_pos    <= n_o_pos;
        r_o_last   <= n_o_last;
    end

    assign o_busy           = (r_state == ES_RUN);
    assign o_out_valid      = r_ov;
    assign o_texel_first    = r_o_first;
    assign o_texel_second   = r_o_second;
    assign o_pair_count     = r_o_cnt;
    assign o_texel_position = r_o_pos;
    assign o_run_last       = r_o_last;

endmodule

### rtl/amd_checker.sv
`include "alpha_map_decoder_defines.svh"

module amd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_texel_first,
    input logic [7:0]  o_texel_second,
    input logic [1:0]  o_pair_count,
    input logic [11:0] o_texel_position,
    input logic        o_run_last
);

    `AMD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_texel_first) && $stable(o_texel_second) && $stable(o_texel_position) && $stable(o_pair_count) && $stable(o_run_last))
    `AMD_ASSERT(a_count_range, i_clk, i_rst_n, o_out_valid |-> (o_pair_count == 2'd1 || o_pair_count == 2'd2))
    `AMD_ASSERT(a_single_zero, i_clk, i_rst_n, o_out_valid && o_pair_count == 2'd1 |-> o_texel_second == 8'd0)
    `AMD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule

bind alpha_map_decoder amd_checker u_amd_checker (.*);
